@@ hdl/zcv_pkg.sv @@
// Shared types and constants of the zero-crossing variance edge detector.
`timescale 1ns / 1ps
`default_nettype none
package zcv_pkg;
  localparam int CFG_W    = 11;
  localparam int THR_W    = 8;
  localparam int LIN_W    = 22;
  localparam int ADDR_W   = 15;
  localparam int MAX_ROWS = 1024;
  localparam logic [7:0] EDGE_VALUE = 8'd255;

  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2
  } reg_idx_t;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              emit;
    logic [ADDR_W-1:0] caddr;
    logic [CFG_W-1:0]  row;
    logic [CFG_W-1:0]  col;
    logic              last;
  } job_t;
endpackage
`default_nettype wire

@@ hdl/zcv_front.sv @@
// Front end: raster counters, emit decision and job building.
`timescale 1ns / 1ps
`default_nettype none
module zcv_front import zcv_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = 13
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  input  wire logic [CFG_W-1:0] cfg_width,
  input  wire logic [CFG_W-1:0] cfg_height,
  output logic [CFG_W-1:0]      w_eff,
  output logic [CFG_W-1:0]      h_eff,
  output logic                  push,
  output job_t                  push_job,
  input  wire logic             q_full
);
  localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH13 = 13'(MAX_ROWS);

  logic [CFG_W-1:0] in_col_r, in_col_nxt, in_row_r, in_row_nxt;
  logic [CFG_W-1:0] out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic [LIN_W-1:0] in_lin_r, in_lin_nxt, out_lin_r, out_lin_nxt;
  logic [AW-1:0]    in_base_r, in_base_nxt, out_base_r, out_base_nxt;
  logic [1:0]       ahead_r, ahead_nxt;
  logic             acc, is_pix, emit;
  logic [23:0]      thresh_pos;

  always_comb begin
    if (cfg_width == '0) w_eff = CFG_W'(1);
    else if ({2'b00, cfg_width} > MAXW13) w_eff = CFG_W'(MAX_WIDTH);
    else w_eff = cfg_width;
    if (cfg_height == '0) h_eff = CFG_W'(1);
    else if ({2'b00, cfg_height} > MAXH13) h_eff = CFG_W'(MAX_ROWS);
    else h_eff = cfg_height;
  end

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;
  assign is_pix   = (in_data.cmd == CMD_PIXEL);
  assign thresh_pos = 24'(out_lin_r) + 24'({w_eff, 1'b0}) + 24'd2;

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_lin_nxt   = in_lin_r;
    in_base_nxt  = in_base_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_lin_nxt  = out_lin_r;
    out_base_nxt = out_base_r;
    ahead_nxt    = ahead_r;
    emit         = 1'b0;
    push_job        = '0;
    push_job.waddr  = ADDR_W'(in_base_r + in_lin_r[AW-1:0]);
    push_job.wdata  = in_data.pixel_in;
    push_job.caddr  = ADDR_W'(out_base_r + out_lin_r[AW-1:0]);
    push_job.row    = out_row_r;
    push_job.col    = out_col_r;
    if (acc) begin
      if (is_pix) begin
        push_job.wr = 1'b1;
        in_lin_nxt  = in_lin_r + LIN_W'(1);
        if (in_col_r + CFG_W'(1) >= w_eff) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + CFG_W'(1);
        end else begin
          in_col_nxt = in_col_r + CFG_W'(1);
        end
        if (in_row_nxt >= h_eff) begin
          in_row_nxt  = '0;
          in_lin_nxt  = '0;
          in_base_nxt = in_base_r + AW'(in_lin_r + LIN_W'(1));
          if (ahead_r != 2'd3) ahead_nxt = ahead_r + 2'd1;
        end
        emit = (ahead_nxt != 2'd0) || (24'(in_lin_r) >= thresh_pos);
      end else begin
        emit = (ahead_r != 2'd0);
      end
      if (emit) begin
        out_lin_nxt = out_lin_r + LIN_W'(1);
        if (out_col_r + CFG_W'(1) >= w_eff) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + CFG_W'(1);
        end else begin
          out_col_nxt = out_col_r + CFG_W'(1);
        end
        if (out_row_nxt >= h_eff) begin
          out_row_nxt   = '0;
          out_lin_nxt   = '0;
          out_base_nxt  = out_base_r + AW'(out_lin_r + LIN_W'(1));
          push_job.last = 1'b1;
          if (ahead_nxt != 2'd0) ahead_nxt = ahead_nxt - 2'd1;
        end
      end
    end
    push_job.emit = emit;
    push = acc && (is_pix || emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_lin_r   <= '0;
      in_base_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_lin_r  <= '0;
      out_base_r <= '0;
      ahead_r    <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_lin_r   <= in_lin_nxt;
      in_base_r  <= in_base_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_lin_r  <= out_lin_nxt;
      out_base_r <= out_base_nxt;
      ahead_r    <= ahead_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hdl/zcv_queue.sv @@
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module zcv_queue import zcv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output job_t      head
);
  job_t       ent_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rd_r];

  always_comb begin
    rd_nxt  = pop ? ~rd_r : rd_r;
    wr_nxt  = push ? ~wr_r : wr_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_job;
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hdl/zcv_back.sv @@
// Back end: row store, window gather, variance test and output register.
`timescale 1ns / 1ps
`default_nettype none
module zcv_back import zcv_pkg::*; #(
  parameter int AW = 13
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_valid,
  input  wire job_t             job,
  output logic                  pop,
  input  wire logic [CFG_W-1:0] w_eff,
  input  wire logic [CFG_W-1:0] h_eff,
  input  wire logic [THR_W-1:0] thr,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_DRAIN, ST_MUL, ST_SUB, ST_CMP
  } state_t;

  logic [7:0] mem [2**AW];

  state_t           state_r;
  logic [2:0]       a_r, b_r;
  logic [AW-1:0]    addr_r;
  logic [CFG_W-1:0] row_r, col_r;
  logic             last_r;
  logic [7:0]       rdata_r;
  logic             vld_d_r, inner_d_r, center_d_r;
  logic [4:0]       k_r;
  logic [12:0]      sum_r;
  logic [20:0]      sumsq_r;
  logic             has_nz_r, has_z_r, bin_r;
  logic [25:0]      m1_r, m2_r, lhs_r, rhs_r;
  logic [12:0]      tk_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic [11:0] ra, cb;
  logic        inframe, inner, load, zc;

  assign ra = {1'b0, row_r} + 12'(a_r);
  assign cb = {1'b0, col_r} + 12'(b_r);
  assign inframe = (ra >= 12'd2) && (ra < {1'b0, h_eff} + 12'd2) &&
                   (cb >= 12'd2) && (cb < {1'b0, w_eff} + 12'd2);
  assign inner = (a_r >= 3'd1) && (a_r <= 3'd3) && (b_r >= 3'd1) && (b_r <= 3'd3);
  assign pop  = (state_r == ST_IDLE) && job_valid;
  assign load = (state_r == ST_CMP) && (!out_valid_r || !out_stall);
  assign zc   = has_nz_r && has_z_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (pop && job.wr) mem[job.waddr[AW-1:0]] <= job.wdata;
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_d_r     <= 1'b0;
      k_r         <= '0;
    end else begin
      vld_d_r <= (state_r == ST_RD) && inframe;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (pop && job.emit) begin
            state_r  <= ST_RD;
            a_r      <= '0;
            b_r      <= '0;
            addr_r   <= AW'(job.caddr[AW-1:0] - AW'({w_eff, 1'b0}) - AW'(2));
            row_r    <= job.row;
            col_r    <= job.col;
            last_r   <= job.last;
            k_r      <= '0;
            sum_r    <= '0;
            sumsq_r  <= '0;
            has_nz_r <= 1'b0;
            has_z_r  <= 1'b0;
            bin_r    <= 1'b0;
          end
        end
        ST_RD: begin
          inner_d_r  <= inner;
          center_d_r <= (a_r == 3'd2) && (b_r == 3'd2);
          if (b_r == 3'd4) begin
            b_r    <= '0;
            a_r    <= a_r + 3'd1;
            addr_r <= addr_r + AW'(w_eff) - AW'(4);
            if (a_r == 3'd4) state_r <= ST_DRAIN;
          end else begin
            b_r    <= b_r + 3'd1;
            addr_r <= addr_r + AW'(1);
          end
        end
        ST_DRAIN: state_r <= ST_MUL;
        ST_MUL: begin
          m1_r    <= 26'(k_r) * 26'(sumsq_r);
          m2_r    <= 26'(sum_r) * 26'(sum_r);
          tk_r    <= 13'(thr) * 13'(k_r);
          state_r <= ST_SUB;
        end
        ST_SUB: begin
          lhs_r   <= m1_r - m2_r;
          rhs_r   <= 26'(tk_r) * 26'(tk_r);
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (load) begin
            out_data_r.pixel_out  <= (zc && lhs_r >= rhs_r) ? EDGE_VALUE : {7'd0, bin_r};
            out_data_r.frame_last <= last_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (vld_d_r) begin
        k_r     <= k_r + 5'd1;
        sum_r   <= sum_r + 13'(rdata_r);
        sumsq_r <= sumsq_r + 21'(rdata_r) * 21'(rdata_r);
        if (inner_d_r && rdata_r != 8'd0) has_nz_r <= 1'b1;
        if (inner_d_r && rdata_r == 8'd0) has_z_r <= 1'b1;
        if (center_d_r) bin_r <= (rdata_r != 8'd0);
      end
    end
  end

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n) k_r <= 5'd25)
    else $error("window count beyond 25");
  a_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> k_r != 5'd0)
    else $error("empty window at variance test");
  a_var_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUB |-> m1_r >= m2_r)
    else $error("negative variance term");
endmodule
`default_nettype wire

@@ hdl/zero_crossing_variance_edge_detector.sv @@
// Top level of the zero-crossing variance edge detector.
// Input channel in_valid/in_stall/in_data carries requests: cmd pixel stores a
// raster sample, cmd flush drains rows still held once a frame is complete.
// Output channel out_valid/out_stall/out_data returns one pixel per emitting
// request: 255 on an edge, else the binary sample, frame_last on the frame end.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, width, height and
// threshold; write only while idle. cfg_ready is always high.
// In the back end a request that emits passes a store write if it holds a
// pixel, 25 window reads from the single read port of the row store, drain,
// two multiply stages and compare; a request that only stores is written in
// the idle state. A two-entry queue lets the front accept while the back works.
// Reset clears counters and control; the row store is not cleared.
// When out_stall holds, the result stays and the back end waits; the queue
// then fills and in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module zero_crossing_variance_edge_detector import zcv_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);
  localparam int AW = $clog2(8 * MAX_WIDTH);

  logic [CFG_W-1:0] width_r, height_r, w_eff, h_eff;
  logic [THR_W-1:0] thr_r;
  logic             push, q_full, pop, not_empty;
  job_t             push_job, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(256);
      height_r <= CFG_W'(256);
      thr_r    <= THR_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:     width_r  <= cfg_data;
        REG_HEIGHT:    height_r <= cfg_data;
        REG_THRESHOLD: thr_r    <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  zcv_front #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cfg_width(width_r), .cfg_height(height_r), .w_eff, .h_eff,
    .push, .push_job, .q_full
  );

  zcv_queue u_queue (
    .clk, .rst_n, .push, .push_job, .full(q_full),
    .pop, .not_empty, .head
  );

  zcv_back #(.AW(AW)) u_back (
    .clk, .rst_n, .job_valid(not_empty), .job(head), .pop,
    .w_eff, .h_eff, .thr(thr_r), .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire
